// File: rtl/core/ipft_pkg.sv
// Package with types and constants shared by the fragment port tracker.
package ipft_pkg;

   localparam int TableEntries  = 16;
   localparam int FragmentLimit = 32;
   localparam int IdxW          = $clog2(TableEntries);
   localparam int CntW          = 6;

   localparam logic [15:0] EthIpv4     = 16'h0800;
   localparam logic [7:0]  ProtoTcp    = 8'd6;
   localparam logic [7:0]  ProtoUdp    = 8'd17;
   localparam int          FlagDfBit   = 14;
   localparam int          FlagMfBit   = 13;
   localparam logic [15:0] OffsetMask  = 16'h1FFF;
   localparam logic [14:0] LifetimeRst = 15'd1000;

   localparam logic [2:0] StRecord   = 3'd0;
   localparam logic [2:0] StTable    = 3'd1;
   localparam logic [2:0] StUnsupp   = 3'd2;
   localparam logic [2:0] StFull     = 3'd3;
   localparam logic [2:0] StLimit    = 3'd4;
   localparam logic [2:0] StTick     = 3'd5;

   localparam logic CsrUdpMode  = 1'b0;
   localparam logic CsrLifetime = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [15:0] frag_field;
      logic [15:0] ip_ident;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        outgoing;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        record_valid;
      logic        is_download;
      logic [31:0] host_addr;
      logic [31:0] peer_addr;
      logic [15:0] host_port;
      logic [15:0] peer_port;
   } rsp_type;

   // Operation broadcast to every cell in the chain.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ALLOC,
      OP_MATCH,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] ident;
      logic [15:0] sport;
      logic [15:0] dport;
      logic        more;
      logic [15:0] now;
      logic [14:0] lifetime;
   } cmd_type;

   // Token passed from cell to cell: a lower cell has already claimed the op.
   typedef struct packed {
      logic        taken;
      logic        limit;
      logic [15:0] sport;
      logic [15:0] dport;
   } chain_type;

endpackage

// File: rtl/core/ipft_cell.sv
// One table entry of the fragment tracker with its claim chain logic.
module ipft_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               apply,
   input  ipft_pkg::cmd_type  cmd,
   input  ipft_pkg::chain_type chain_in,
   output ipft_pkg::chain_type chain_out
);
   import ipft_pkg::*;

   logic              live_ff, live_in;
   logic [15:0]       ident_ff, sport_ff, dport_ff, start_ff;
   logic [CntW-1:0]   count_ff;
   logic              hit;
   logic              aged;
   logic [CntW:0]     next_cnt;

   assign aged = live_ff && ((cmd.now - start_ff) >= {1'b0, cmd.lifetime});
   assign next_cnt = {1'b0, count_ff} + 1'b1;

   always_comb begin
      chain_out = chain_in;
      hit       = 1'b0;
      live_in   = live_ff;
      unique case (cmd.op)
         OP_ALLOC: begin
            hit = !chain_in.taken && !live_ff;
            if (hit) begin
               chain_out.taken = 1'b1;
               live_in = 1'b1;
            end
         end
         OP_MATCH: begin
            hit = !chain_in.taken && live_ff && ident_ff == cmd.ident;
            if (hit) begin
               chain_out.taken = 1'b1;
               chain_out.sport = sport_ff;
               chain_out.dport = dport_ff;
               if (next_cnt > (CntW+1)'(FragmentLimit)) begin
                  chain_out.limit = 1'b1;
               end else if (!cmd.more) begin
                  live_in = 1'b0;
               end
            end
         end
         OP_TICK: begin
            if (aged) begin
               live_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else if (apply) begin
         live_ff <= live_in;
      end
      if (apply && hit) begin
         if (cmd.op == OP_ALLOC) begin
            ident_ff <= cmd.ident;
            sport_ff <= cmd.sport;
            dport_ff <= cmd.dport;
            start_ff <= cmd.now;
            count_ff <= CntW'(1);
         end else if (next_cnt > (CntW+1)'(FragmentLimit)) begin
            count_ff <= CntW'(FragmentLimit);
         end else begin
            count_ff <= next_cnt[CntW-1:0];
         end
      end
   end
endmodule

// File: rtl/core/ip_fragment_port_tracker_core.sv
// Top level of the IPv4 fragment port tracker: decode, cell chain and result register.
// Order: the accepted request is registered, the cell chain settles and the entries update in
// the execute cycle, and the result and its strobe are registered from that cycle.
// Busy is high for the cycle after acceptance, while the row of entry cells settles the
// claim chain and updates; no new request is accepted while busy is high.
// Reset (synchronous, active high) frees every entry, clears the tick counter and
// restores the registers to TCP tracking with a lifetime of 1000 ticks.
module ip_fragment_port_tracker_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ipft_pkg::req_type req_data,
   output logic              rsp_valid,
   output ipft_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [14:0]       csr_wdata
);
   import ipft_pkg::*;

   // Configuration registers.
   logic        udp_mode_ff;
   logic [14:0] lifetime_ff;
   logic [15:0] tick_ff;

   // The request is held for its execute cycle.
   logic        exec_ff;
   req_type     req_ff;

   cmd_type     cmd;
   chain_type   chain [TableEntries+1];

   logic        unsupp, df, more, first, later;
   logic [15:0] offset;

   assign busy = exec_ff;

   // Classification of the held request.
   always_comb begin
      offset = req_ff.frag_field & OffsetMask;
      df     = req_ff.frag_field[FlagDfBit];
      more   = req_ff.frag_field[FlagMfBit];
      unsupp = (req_ff.ether_type != EthIpv4) ||
               !((req_ff.ip_protocol == ProtoTcp && !udp_mode_ff) ||
                 (req_ff.ip_protocol == ProtoUdp && udp_mode_ff));
      first  = !df && more && offset == 16'd0;
      later  = !df && offset != 16'd0;

      cmd.ident    = req_ff.ip_ident;
      cmd.sport    = req_ff.src_port;
      cmd.dport    = req_ff.dst_port;
      cmd.more     = more;
      cmd.lifetime = lifetime_ff;
      if (req_ff.action) begin
         cmd.op  = OP_TICK;
         cmd.now = tick_ff + 16'd1;
      end else begin
         cmd.now = tick_ff;
         if (unsupp)     cmd.op = OP_NONE;
         else if (first) cmd.op = OP_ALLOC;
         else if (later) cmd.op = OP_MATCH;
         else            cmd.op = OP_NONE;
      end
   end

   assign chain[0] = '{taken: 1'b0, limit: 1'b0,
                       sport: req_ff.src_port, dport: req_ff.dst_port};

   // Entries form a chain: the first free or matching cell claims the request.
   for (genvar g = 0; g < TableEntries; g++) begin : g_cell
      ipft_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .apply     (exec_ff),
         .cmd       (cmd),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1])
      );
   end

   // Result formation.
   rsp_type rsp_in;
   logic [2:0]  st;
   logic        rec;
   logic [15:0] sp, dp;
   always_comb begin
      sp = chain[TableEntries].sport;
      dp = chain[TableEntries].dport;
      rec = 1'b1;
      st  = StRecord;
      if (req_ff.action) begin
         rec = 1'b0; st = StTick;
      end else if (unsupp) begin
         rec = 1'b0; st = StUnsupp;
      end else if (cmd.op == OP_ALLOC && !chain[TableEntries].taken) begin
         rec = 1'b0; st = StFull;
      end else if (cmd.op == OP_MATCH && chain[TableEntries].limit) begin
         rec = 1'b0; st = StLimit;
      end else if (cmd.op == OP_MATCH && chain[TableEntries].taken) begin
         st = StTable;
      end
      rsp_in = '0;
      rsp_in.status = st;
      if (rec) begin
         rsp_in.record_valid = 1'b1;
         rsp_in.is_download  = !req_ff.outgoing;
         rsp_in.host_addr = req_ff.outgoing ? req_ff.source_address
                                            : req_ff.dest_address;
         rsp_in.peer_addr = req_ff.outgoing ? req_ff.dest_address
                                            : req_ff.source_address;
         rsp_in.host_port = req_ff.outgoing ? sp : dp;
         rsp_in.peer_port = req_ff.outgoing ? dp : sp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         udp_mode_ff <= 1'b0;
         lifetime_ff <= LifetimeRst;
         tick_ff     <= '0;
         exec_ff     <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CsrUdpMode:  udp_mode_ff <= csr_wdata[0];
               CsrLifetime: lifetime_ff <= csr_wdata;
               default: ;
            endcase
         end
         exec_ff   <= start && !exec_ff;
         rsp_valid <= exec_ff;
         if (exec_ff && req_ff.action) begin
            tick_ff <= cmd.now;
         end
      end
      if (start && !exec_ff) begin
         req_ff <= req_data;
      end
      if (exec_ff) begin
         rsp_data <= rsp_in;
      end
   end
endmodule

// File: tb/ip_fragment_port_tracker_core_tb.sv
// Self-checking testbench for the IPv4 fragment port tracker core.
`timescale 1ns / 100ps

module ip_fragment_port_tracker_core_tb;
   import ipft_pkg::*;

   localparam int StallLimit = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic [14:0] csr_wdata = '0;

   ip_fragment_port_tracker_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow of the tracker state, advanced once per accepted request.
   logic        tr_udp;
   logic [14:0] tr_lifetime;
   logic        tr_live [TableEntries];
   logic [15:0] tr_ident [TableEntries];
   logic [15:0] tr_sport [TableEntries];
   logic [15:0] tr_dport [TableEntries];
   int          tr_count [TableEntries];
   logic [15:0] tr_start [TableEntries];
   logic [15:0] tr_now;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      gap_left = 0;

   function automatic rsp_type flow_record(logic [2:0] st, req_type r,
                                           logic [15:0] sp, logic [15:0] dp);
      rsp_type o;
      o.status       = st;
      o.record_valid = 1'b1;
      o.is_download  = ~r.outgoing;
      o.host_addr    = r.outgoing ? r.source_address : r.dest_address;
      o.peer_addr    = r.outgoing ? r.dest_address : r.source_address;
      o.host_port    = r.outgoing ? sp : dp;
      o.peer_port    = r.outgoing ? dp : sp;
      return o;
   endfunction

   function automatic rsp_type empty_record(logic [2:0] st);
      rsp_type o = '0;
      o.status = st;
      return o;
   endfunction

   // Applies one request to the shadow table and returns the record it yields.
   function automatic rsp_type track_request(req_type r);
      logic [12:0] offset;
      logic        more;
      offset = r.frag_field[12:0];
      more   = r.frag_field[FlagMfBit];
      if (r.action) begin
         tr_now = tr_now + 16'd1;
         for (int i = 0; i < TableEntries; i++)
            if (tr_live[i] && (tr_now - tr_start[i]) >= {1'b0, tr_lifetime})
               tr_live[i] = 1'b0;
         return empty_record(StTick);
      end
      if (r.ether_type != EthIpv4) return empty_record(StUnsupp);
      if (!((r.ip_protocol == ProtoTcp && !tr_udp) || (r.ip_protocol == ProtoUdp && tr_udp)))
         return empty_record(StUnsupp);
      if (r.frag_field[FlagDfBit])
         return flow_record(StRecord, r, r.src_port, r.dst_port);
      if (more && offset == 0) begin
         for (int i = 0; i < TableEntries; i++)
            if (!tr_live[i]) begin
               tr_live[i]  = 1'b1;
               tr_ident[i] = r.ip_ident;
               tr_sport[i] = r.src_port;
               tr_dport[i] = r.dst_port;
               tr_count[i] = 1;
               tr_start[i] = tr_now;
               return flow_record(StRecord, r, r.src_port, r.dst_port);
            end
         return empty_record(StFull);
      end
      if (offset != 0)
         for (int i = 0; i < TableEntries; i++)
            if (tr_live[i] && tr_ident[i] == r.ip_ident) begin
               if (tr_count[i] + 1 > FragmentLimit) begin
                  tr_count[i] = FragmentLimit;
                  return empty_record(StLimit);
               end
               tr_count[i]++;
               if (!more) tr_live[i] = 1'b0;
               return flow_record(StTable, r, tr_sport[i], tr_dport[i]);
            end
      return flow_record(StRecord, r, r.src_port, r.dst_port);
   endfunction

   // Driver: one request at a time from the pending queue, with random gaps.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(track_request(req_data));
         end
         if (start && busy) begin
            // Hold the current request until it is taken.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            start    <= 1'b1;
            gap_left <= ($urandom_range(0, 9) < 6) ? 0 :
                        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 30);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is compared with the oldest expected record.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %p", rsp_data);
         end else begin
            rsp_type exp_rsp;
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   // Watchdog on cycles in which nothing is accepted or answered.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("FAIL ip_fragment_port_tracker_core");
         $finish;
      end
   end

   function automatic req_type packet(logic [7:0] proto, logic [15:0] frag,
                                      logic [15:0] ident);
      req_type r;
      r.action         = 1'b0;
      r.ether_type     = EthIpv4;
      r.ip_protocol    = proto;
      r.frag_field     = frag;
      r.ip_ident       = ident;
      r.source_address = $urandom;
      r.dest_address   = $urandom;
      r.src_port       = 16'($urandom);
      r.dst_port       = 16'($urandom);
      r.outgoing       = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic req_type tick_req();
      req_type r;
      r        = packet(ProtoTcp, 16'h0, 16'h0);
      r.action = 1'b1;
      return r;
   endfunction

   function automatic logic [15:0] later_frag(bit last);
      logic [15:0] f;
      f = {3'b000, 13'($urandom_range(1, 8191))};
      f[FlagMfBit] = !last;
      f[15] = 1'($urandom_range(0, 1));
      return f;
   endfunction

   task automatic csr_write(logic idx, logic [14:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CsrUdpMode) tr_udp = value[0];
      else tr_lifetime = value;
   endtask

   // Waits until every queued request is accepted and answered, then settles.
   task automatic drain();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Random phase: mostly well-formed fragment trains, with noise and ticks.
   task automatic random_traffic(int count, logic [7:0] proto);
      logic [15:0] ident;
      int          n;
      req_type     r;
      while (count > 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               ident = 16'($urandom_range(0, 23));
               n     = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                   : $urandom_range(1, 5);
               pending_reqs.push_back(packet(proto, 16'h2000, ident));
               for (int k = 0; k < n; k++)
                  pending_reqs.push_back(packet(proto, later_frag(k == n - 1 &&
                                                $urandom_range(0, 3) != 0), ident));
               count -= n + 1;
            end
            4: begin
               pending_reqs.push_back(tick_req());
               count--;
            end
            5: begin
               r = packet(proto, 16'($urandom), 16'($urandom_range(0, 23)));
               pending_reqs.push_back(r);
               count--;
            end
            6: begin
               r = packet(8'($urandom), 16'($urandom), 16'($urandom));
               r.ether_type = ($urandom_range(0, 1)) ? EthIpv4 : 16'($urandom);
               r.action     = 1'b0;
               pending_reqs.push_back(r);
               count--;
            end
            default: begin
               r = packet(proto, later_frag(1'($urandom_range(0, 1))),
                          16'($urandom_range(0, 23)));
               pending_reqs.push_back(r);
               count--;
            end
         endcase
      end
   endtask

   initial begin
      req_type r;
      tr_udp      = 1'b0;
      tr_lifetime = LifetimeRst;
      tr_now      = '0;
      for (int i = 0; i < TableEntries; i++) begin
         tr_live[i]  = 1'b0;
         tr_ident[i] = '0;
         tr_sport[i] = '0;
         tr_dport[i] = '0;
         tr_count[i] = 0;
         tr_start[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: plain, DF, unsupported, a full table, a match, a miss and a tick.
      r = packet(ProtoTcp, 16'h0, 16'h0);
      r.source_address = '1; r.dest_address = '0; r.src_port = '1; r.dst_port = '0;
      pending_reqs.push_back(r);
      pending_reqs.push_back(packet(ProtoTcp, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(packet(ProtoUdp, 16'h0, 16'h1));
      r = packet(ProtoTcp, 16'h0, 16'h0); r.ether_type = 16'h86DD;
      pending_reqs.push_back(r);
      for (int i = 0; i < TableEntries + 1; i++)
         pending_reqs.push_back(packet(ProtoTcp, 16'h2000, 16'(i)));
      pending_reqs.push_back(packet(ProtoTcp, 16'h0001, 16'd3));
      pending_reqs.push_back(packet(ProtoTcp, 16'h3FFF, 16'd4));
      pending_reqs.push_back(packet(ProtoTcp, 16'h0005, 16'd999));
      pending_reqs.push_back(tick_req());
      drain();

      // Zero lifetime and one tick clear the table, then fill one entry up to the fragment limit.
      csr_write(CsrLifetime, 15'd0);
      pending_reqs.push_back(tick_req());
      drain();
      csr_write(CsrLifetime, 15'h7FFF);
      pending_reqs.push_back(packet(ProtoTcp, 16'h2000, 16'd77));
      for (int k = 0; k < FragmentLimit + 1; k++)
         pending_reqs.push_back(packet(ProtoTcp, 16'h2008, 16'd77));
      drain();
      random_traffic(150, ProtoTcp);
      drain();

      csr_write(CsrUdpMode, 15'd1);
      csr_write(CsrLifetime, 15'd1);
      random_traffic(160, ProtoUdp);
      drain();

      csr_write(CsrLifetime, 15'd3);
      random_traffic(160, ProtoUdp);
      drain();

      csr_write(CsrUdpMode, 15'd0);
      csr_write(CsrLifetime, 15'd6);
      random_traffic(160, ProtoTcp);
      drain();

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("PASS ip_fragment_port_tracker_core");
      else
         $display("FAIL ip_fragment_port_tracker_core");
      $finish;
   end

endmodule
